// ----- hdl/dtrc_pkg.sv -----
// Shared types, constants and helpers of the dirty tile row coalescer.
`default_nettype none
package dtrc_pkg;

   localparam int MAX_COLUMNS = 64;
   localparam int COORD_BITS  = 14;
   localparam int COL_BITS    = $clog2(MAX_COLUMNS);
   // Column index plus one, and tile_columns as written.
   localparam int COLS_BITS   = 7;
   localparam int TILE_BITS   = 9;
   localparam int FRAME_BITS  = 14;
   // Wide enough for (column + 1) * tile size and for a coordinate plus a tile size.
   localparam int WIDE_BITS   = 17;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 14;
   localparam int RSP_DATA_BITS = ((4 * COORD_BITS + 7) / 8) * 8;
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [WIDE_BITS-1:0]  wide_type;

   localparam coord_type COORD_MAX = '1;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      REG_TILE_WIDTH   = 3'd0,
      REG_TILE_HEIGHT  = 3'd1,
      REG_FRAME_WIDTH  = 3'd2,
      REG_FRAME_HEIGHT = 3'd3,
      REG_TILE_COLUMNS = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [TILE_BITS-1:0]  tile_width;
      logic [TILE_BITS-1:0]  tile_height;
      logic [FRAME_BITS-1:0] frame_width;
      logic [FRAME_BITS-1:0] frame_height;
      logic [COLS_BITS-1:0]  tile_columns;
   } cfg_type;

   typedef struct packed {
      coord_type box_left;
      coord_type box_top;
      coord_type box_right;
      coord_type box_bottom;
      logic      final_region;
      logic      no_region;
   } result_type;

   // Results of one processed item, in order: first, then second.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   function automatic coord_type clip(wide_type value, coord_type limit);
      if (value < wide_type'(limit)) begin
         return coord_type'(value);
      end
      return limit;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/dtrc_csr.sv -----
// Configuration registers of the dirty tile row coalescer.
`default_nettype none
module dtrc_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [dtrc_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [dtrc_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output dtrc_pkg::cfg_type                      cfg
);

   dtrc_pkg::cfg_type cfg_ff;
   dtrc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (dtrc_pkg::reg_index_type'(csr_addr))
            dtrc_pkg::REG_TILE_WIDTH:
               cfg_in.tile_width = csr_wdata[dtrc_pkg::TILE_BITS-1:0];
            dtrc_pkg::REG_TILE_HEIGHT:
               cfg_in.tile_height = csr_wdata[dtrc_pkg::TILE_BITS-1:0];
            dtrc_pkg::REG_FRAME_WIDTH:
               cfg_in.frame_width = csr_wdata[dtrc_pkg::FRAME_BITS-1:0];
            dtrc_pkg::REG_FRAME_HEIGHT:
               cfg_in.frame_height = csr_wdata[dtrc_pkg::FRAME_BITS-1:0];
            dtrc_pkg::REG_TILE_COLUMNS:
               cfg_in.tile_columns = csr_wdata[dtrc_pkg::COLS_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tile_width   <= dtrc_pkg::TILE_BITS'(64);
         cfg_ff.tile_height  <= dtrc_pkg::TILE_BITS'(64);
         cfg_ff.frame_width  <= dtrc_pkg::FRAME_BITS'(1920);
         cfg_ff.frame_height <= dtrc_pkg::FRAME_BITS'(1080);
         cfg_ff.tile_columns <= dtrc_pkg::COLS_BITS'(30);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ----- hdl/dtrc_core.sv -----
// Input register, row box forming and held box merge of the coalescer.
`default_nettype none
module dtrc_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  dtrc_pkg::cfg_type                    cfg,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [dtrc_pkg::MAX_COLUMNS-1:0] req_tdata,
   input  wire logic                            req_tlast,
   input  wire logic                            fifo_room,
   output dtrc_pkg::push_type                   push
);

   logic                            s1_valid_ff, s1_valid_in;
   logic [dtrc_pkg::MAX_COLUMNS-1:0] s1_mask_ff;
   logic                            s1_last_ff;

   logic                 held_valid_ff, held_valid_in;
   dtrc_pkg::coord_type  held_left_ff, held_left_in;
   dtrc_pkg::coord_type  held_top_ff, held_top_in;
   dtrc_pkg::coord_type  held_right_ff, held_right_in;
   dtrc_pkg::coord_type  held_bottom_ff, held_bottom_in;
   dtrc_pkg::coord_type  row_origin_ff, row_origin_in;

   logic                             fire;
   logic [dtrc_pkg::COLS_BITS-1:0]   cols;
   logic [dtrc_pkg::MAX_COLUMNS-1:0] mask;
   logic [dtrc_pkg::COL_BITS-1:0]    lo_idx, hi_idx;
   dtrc_pkg::coord_type              fw, fh;
   dtrc_pkg::coord_type              new_left, new_top, new_right, new_bottom;
   logic                             merge, emit_held;
   dtrc_pkg::result_type             held_box, final_box;

   function automatic logic [dtrc_pkg::COL_BITS-1:0] lowest_set(
      logic [dtrc_pkg::MAX_COLUMNS-1:0] bits);
      logic [dtrc_pkg::COL_BITS-1:0] idx;
      idx = '0;
      for (int i = dtrc_pkg::MAX_COLUMNS - 1; i >= 0; i--) begin
         if (bits[i]) idx = dtrc_pkg::COL_BITS'(i);
      end
      return idx;
   endfunction

   function automatic logic [dtrc_pkg::COL_BITS-1:0] highest_set(
      logic [dtrc_pkg::MAX_COLUMNS-1:0] bits);
      logic [dtrc_pkg::COL_BITS-1:0] idx;
      idx = '0;
      for (int i = 0; i < dtrc_pkg::MAX_COLUMNS; i++) begin
         if (bits[i]) idx = dtrc_pkg::COL_BITS'(i);
      end
      return idx;
   endfunction

   // The register stage advances only when the result queue can take two items.
   assign fire        = s1_valid_ff && fifo_room;
   assign req_tready  = !s1_valid_ff || fire;
   assign s1_valid_in = (req_tvalid && req_tready) || (s1_valid_ff && !fire);

   always_comb begin
      if (cfg.tile_columns > dtrc_pkg::COLS_BITS'(dtrc_pkg::MAX_COLUMNS)) begin
         cols = dtrc_pkg::COLS_BITS'(dtrc_pkg::MAX_COLUMNS);
      end else begin
         cols = cfg.tile_columns;
      end
      for (int i = 0; i < dtrc_pkg::MAX_COLUMNS; i++) begin
         mask[i] = s1_mask_ff[i] && (dtrc_pkg::COLS_BITS'(i) < cols);
      end
      lo_idx = lowest_set(mask);
      hi_idx = highest_set(mask);

      fw = dtrc_pkg::clip(dtrc_pkg::wide_type'(cfg.frame_width), dtrc_pkg::COORD_MAX);
      fh = dtrc_pkg::clip(dtrc_pkg::wide_type'(cfg.frame_height), dtrc_pkg::COORD_MAX);

      new_left   = dtrc_pkg::clip(dtrc_pkg::wide_type'(lo_idx)
                                  * dtrc_pkg::wide_type'(cfg.tile_width), fw);
      new_right  = dtrc_pkg::clip((dtrc_pkg::wide_type'(hi_idx) + dtrc_pkg::wide_type'(1))
                                  * dtrc_pkg::wide_type'(cfg.tile_width), fw);
      new_top    = dtrc_pkg::clip(dtrc_pkg::wide_type'(row_origin_ff), fh);
      new_bottom = dtrc_pkg::clip(dtrc_pkg::wide_type'(row_origin_ff)
                                  + dtrc_pkg::wide_type'(cfg.tile_height), fh);

      merge     = held_valid_ff && (held_bottom_ff == new_top)
                  && (held_left_ff == new_left) && (held_right_ff == new_right);
      emit_held = (mask != '0) && held_valid_ff && !merge;

      held_box.box_left     = held_left_ff;
      held_box.box_top      = held_top_ff;
      held_box.box_right    = held_right_ff;
      held_box.box_bottom   = held_bottom_ff;
      held_box.final_region = 1'b0;
      held_box.no_region    = 1'b0;

      held_valid_in  = held_valid_ff;
      held_left_in   = held_left_ff;
      held_top_in    = held_top_ff;
      held_right_in  = held_right_ff;
      held_bottom_in = held_bottom_ff;
      if (mask != '0) begin
         held_valid_in  = 1'b1;
         held_bottom_in = new_bottom;
         if (!merge) begin
            held_left_in  = new_left;
            held_top_in   = new_top;
            held_right_in = new_right;
         end
      end

      // The flush carries the box as it stands after this row.
      if (held_valid_in) begin
         final_box.box_left   = held_left_in;
         final_box.box_top    = held_top_in;
         final_box.box_right  = held_right_in;
         final_box.box_bottom = held_bottom_in;
         final_box.no_region  = 1'b0;
      end else begin
         final_box.box_left   = '0;
         final_box.box_top    = '0;
         final_box.box_right  = '0;
         final_box.box_bottom = '0;
         final_box.no_region  = 1'b1;
      end
      final_box.final_region = 1'b1;

      push.count  = fire ? (2'(emit_held) + 2'(s1_last_ff)) : 2'd0;
      push.first  = emit_held ? held_box : final_box;
      push.second = final_box;

      if (s1_last_ff) begin
         held_valid_in  = 1'b0;
         held_left_in   = '0;
         held_top_in    = '0;
         held_right_in  = '0;
         held_bottom_in = '0;
         row_origin_in  = '0;
      end else begin
         row_origin_in = new_bottom;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         held_valid_ff  <= 1'b0;
         held_left_ff   <= '0;
         held_top_ff    <= '0;
         held_right_ff  <= '0;
         held_bottom_ff <= '0;
         row_origin_ff  <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (fire) begin
            held_valid_ff  <= held_valid_in;
            held_left_ff   <= held_left_in;
            held_top_ff    <= held_top_in;
            held_right_ff  <= held_right_in;
            held_bottom_ff <= held_bottom_in;
            row_origin_ff  <= row_origin_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_mask_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/dtrc_fifo.sv -----
// Result queue of the coalescer: takes up to two items a cycle, gives one.
`default_nettype none
module dtrc_fifo (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  dtrc_pkg::push_type                       push,
   output logic                                     fifo_room,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [dtrc_pkg::RSP_DATA_BITS-1:0]       rsp_tdata,
   output logic                                     rsp_tlast,
   output logic                                     rsp_tuser
);

   localparam int CNT_BITS = dtrc_pkg::FIFO_PTR_BITS + 1;

   dtrc_pkg::result_type                 entry_ff [dtrc_pkg::FIFO_DEPTH];
   logic [dtrc_pkg::FIFO_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [dtrc_pkg::FIFO_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]                  count_ff, count_in;
   logic                                 pop;
   logic [dtrc_pkg::FIFO_PTR_BITS-1:0]   wr_next;
   dtrc_pkg::result_type                 head;

   assign pop       = (count_ff != '0) && rsp_tready;
   assign wr_next   = wr_ptr_ff + dtrc_pkg::FIFO_PTR_BITS'(1);
   assign fifo_room = count_ff <= CNT_BITS'(dtrc_pkg::FIFO_DEPTH - 2);
   assign wr_ptr_in = wr_ptr_ff + dtrc_pkg::FIFO_PTR_BITS'(push.count);
   assign rd_ptr_in = rd_ptr_ff + dtrc_pkg::FIFO_PTR_BITS'(pop);
   assign count_in  = count_ff + CNT_BITS'(push.count) - CNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

   assign head       = entry_ff[rd_ptr_ff];
   assign rsp_tvalid = count_ff != '0;
   assign rsp_tdata  = dtrc_pkg::RSP_DATA_BITS'({head.box_bottom, head.box_right,
                                                 head.box_top, head.box_left});
   assign rsp_tlast  = head.final_region;
   assign rsp_tuser  = head.no_region;

endmodule
`default_nettype wire

// ----- hdl/dirty_tile_row_coalescer.sv -----
// Top level of the dirty tile row coalescer.
//
//   Channel   Direction  Payload
//   req_*     in         tdata: row_mask[63:0]; tlast: last_row
//   rsp_*     out        tdata: box_left, box_top, box_right, box_bottom; tlast:
//                        final_region; tuser: no_region
//   csr_*     in         write enable, register index, write data
//
// One tile row is taken every cycle while the result queue has two free entries.
// An accepted row is processed from the input register, and its results pass through
// the result queue registers before they show on rsp_*.
// Results leave one per cycle while rsp_tready holds; two-result rows drain at that pace.
// Synchronous active-high reset clears control and box state and loads default registers.
// A stalled rsp_tready backs up the queue and then drops req_tready.
`default_nettype none
module dirty_tile_row_coalescer (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [dtrc_pkg::MAX_COLUMNS-1:0]     req_tdata,   // row_mask
   input  wire logic                                 req_tlast,   // last_row
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // box_left, box_top, box_right, box_bottom from the lowest bit up
   output logic [dtrc_pkg::RSP_DATA_BITS-1:0]        rsp_tdata,
   output logic                                      rsp_tlast,   // final_region
   output logic                                      rsp_tuser,   // no_region
   input  wire logic                                 csr_we,
   input  wire logic [dtrc_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  wire logic [dtrc_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   dtrc_pkg::cfg_type  cfg;
   dtrc_pkg::push_type push;
   logic               fifo_room;

   dtrc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dtrc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .fifo_room  (fifo_room),
      .push       (push)
   );

   dtrc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .fifo_room  (fifo_room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

// ----- hdl/dtrc_checker.sv -----
// Port-level checks of the coalescer and the bind that attaches them.
`default_nettype none
module dtrc_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [dtrc_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input wire logic                            rsp_tlast,
   input wire logic                            rsp_tuser
);

   localparam int CB = dtrc_pkg::COORD_BITS;

   // A no-region marker is always the closing item of a frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("no-region item without final flag");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("no-region item with nonzero box");

   // Every real box has non-negative extent.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         (rsp_tdata[CB-1:0] <= rsp_tdata[3*CB-1:2*CB])
         && (rsp_tdata[2*CB-1:CB] <= rsp_tdata[4*CB-1:3*CB]))
      else $error("box edges out of order");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result item changed");

endmodule

bind dirty_tile_row_coalescer dtrc_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for the dirty tile row coalescer.
`timescale 1ns / 100ps
module tb_top;
   import dtrc_pkg::*;

   localparam int QUIET_LIMIT    = 2000;
   localparam int SETTLE_CYCLES  = 6;
   localparam int DRAIN_CYCLES   = 8;
   localparam int RANDOM_PHASES  = 10;
   localparam int ROWS_PER_PHASE = 50;
   localparam int MAX_REPORTS    = 10;
   localparam int MAX_WAIT       = 17;

   typedef struct packed {
      logic [MAX_COLUMNS-1:0] mask;
      logic                   last;
   } tile_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [MAX_COLUMNS-1:0]   req_tdata  = '0;   // row_mask
   logic                     req_tlast  = 1'b0; // last_row
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // box_left, box_top, box_right, box_bottom from the lowest bit up
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tlast;         // final_region
   logic                     rsp_tuser;         // no_region
   logic                     csr_we     = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata  = '0;

   dirty_tile_row_coalescer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow of the block's registers and coalescing state.
   cfg_type      cfg_shadow;
   logic         held_valid = 1'b0;
   result_type   held_box   = '0;
   coord_type    row_top    = '0;
   result_type   box_expect[$];
   tile_row_type row_queue[$];

   int unsigned rows_queued   = 0;
   int unsigned rows_accepted = 0;
   int unsigned mismatches    = 0;
   int unsigned quiet_cycles  = 0;
   logic        req_took      = 1'b0;
   logic        rsp_took      = 1'b0;

   function automatic coord_type clip_to(longint unsigned value, longint unsigned limit);
      return coord_type'((value < limit) ? value : limit);
   endfunction

   function automatic result_type make_box(coord_type l, coord_type t, coord_type r,
                                           coord_type b, logic fin, logic none);
      result_type box;
      box.box_left     = l;
      box.box_top      = t;
      box.box_right    = r;
      box.box_bottom   = b;
      box.final_region = fin;
      box.no_region    = none;
      return box;
   endfunction

   // Applies one accepted tile row to the shadow state and queues the boxes it emits.
   function automatic void predict_row(logic [MAX_COLUMNS-1:0] mask_in, logic last);
      logic [MAX_COLUMNS-1:0] mask;
      longint unsigned        cols, tw, th, fw, fh, lo, hi;
      coord_type              l, t, r, b;
      bit                     found;
      int                     i;
      mask = mask_in;
      cols = 64'(cfg_shadow.tile_columns);
      if (cols > 64'(MAX_COLUMNS)) cols = 64'(MAX_COLUMNS);
      tw = 64'(cfg_shadow.tile_width);
      th = 64'(cfg_shadow.tile_height);
      fw = 64'(cfg_shadow.frame_width);
      fh = 64'(cfg_shadow.frame_height);
      if (fw > 64'(COORD_MAX)) fw = 64'(COORD_MAX);
      if (fh > 64'(COORD_MAX)) fh = 64'(COORD_MAX);
      if (cols < 64'(MAX_COLUMNS)) mask &= (64'd1 << cols) - 64'd1;
      found = 1'b0;
      lo = 0;
      hi = 0;
      for (i = 0; i < MAX_COLUMNS; i++) begin
         if (mask[i]) begin
            if (!found) begin
               lo = 64'(i);
               found = 1'b1;
            end
            hi = 64'(i);
         end
      end
      if (found) begin
         l = clip_to(lo * tw, fw);
         r = clip_to((hi + 64'd1) * tw, fw);
         t = clip_to(64'(row_top), fh);
         b = clip_to(64'(row_top) + th, fh);
         if (held_valid && held_box.box_bottom == t && held_box.box_left == l &&
             held_box.box_right == r) begin
            held_box.box_bottom = b;
         end else begin
            if (held_valid) box_expect = {box_expect, held_box};
            held_valid = 1'b1;
            held_box = make_box(l, t, r, b, 1'b0, 1'b0);
         end
      end
      if (last) begin
         if (held_valid) begin
            held_box.final_region = 1'b1;
            box_expect = {box_expect, held_box};
         end else begin
            box_expect = {box_expect, make_box('0, '0, '0, '0, 1'b1, 1'b1)};
         end
         held_valid = 1'b0;
         held_box = '0;
         row_top = '0;
      end else begin
         row_top = clip_to(64'(row_top) + th, fh);
      end
   endfunction

   function automatic int unsigned draw_wait(bit calm);
      if (calm) return 0;
      if ($urandom_range(0, 2) == 0) return $urandom_range(0, MAX_WAIT);
      return $urandom_range(0, 1);
   endfunction

   // Row driver: holds an item until it is taken, then waits its drawn gap.
   tile_row_type pending_row;
   int unsigned  req_gap  = 0;
   bit           req_calm = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_took) begin
         // Item still waiting for the handshake.
      end else if (req_gap != 0) begin
         req_tvalid <= 1'b0;
         req_gap <= req_gap - 1;
      end else if (row_queue.size() != 0) begin
         pending_row = row_queue.pop_front();
         req_tdata <= pending_row.mask;
         req_tlast <= pending_row.last;
         req_tvalid <= 1'b1;
         if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
         req_gap <= draw_wait(req_calm);
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Result sink: after each taken item it may stall for a drawn number of cycles.
   int unsigned rsp_gap  = 0;
   bit          rsp_calm = 1'b0;

   always @(negedge clock) begin
      if (rsp_took) begin
         if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
         rsp_gap = draw_wait(rsp_calm);
      end
      if (rsp_gap != 0) begin
         rsp_tready <= 1'b0;
         rsp_gap = rsp_gap - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : monitor
      result_type got, want;
      req_took <= !reset && req_tvalid && req_tready;
      rsp_took <= !reset && rsp_tvalid && rsp_tready;
      if (!reset && req_tvalid && req_tready) begin
         predict_row(req_tdata, req_tlast);
         rows_accepted++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = make_box(rsp_tdata[0 +: COORD_BITS], rsp_tdata[COORD_BITS +: COORD_BITS],
                        rsp_tdata[2*COORD_BITS +: COORD_BITS],
                        rsp_tdata[3*COORD_BITS +: COORD_BITS], rsp_tlast, rsp_tuser);
         if (box_expect.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected box: l=%0d t=%0d r=%0d b=%0d final=%0b none=%0b",
                        got.box_left, got.box_top, got.box_right, got.box_bottom,
                        got.final_region, got.no_region);
         end else begin
            want = box_expect.pop_front();
            if (got.box_left !== want.box_left || got.box_top !== want.box_top ||
                got.box_right !== want.box_right || got.box_bottom !== want.box_bottom ||
                got.final_region !== want.final_region || got.no_region !== want.no_region)
            begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("box mismatch: expected l=%0d t=%0d r=%0d b=%0d ",
                           want.box_left, want.box_top, want.box_right, want.box_bottom,
                           "final=%0b none=%0b, ", want.final_region, want.no_region,
                           "got l=%0d t=%0d r=%0d b=%0d ",
                           got.box_left, got.box_top, got.box_right, got.box_bottom,
                           "final=%0b none=%0b", got.final_region, got.no_region);
            end
         end
      end
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   always @(posedge clock) begin
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic queue_row(logic [MAX_COLUMNS-1:0] mask, logic last);
      tile_row_type item_row;
      item_row.mask = mask;
      item_row.last = last;
      row_queue = {row_queue, item_row};
      rows_queued++;
   endtask

   // Rows that emit nothing may still be in flight, so let a few cycles pass.
   task automatic wait_idle();
      while (rows_accepted != rows_queued || box_expect.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      case (idx)
         REG_TILE_WIDTH:   cfg_shadow.tile_width   = value[TILE_BITS-1:0];
         REG_TILE_HEIGHT:  cfg_shadow.tile_height  = value[TILE_BITS-1:0];
         REG_FRAME_WIDTH:  cfg_shadow.frame_width  = value[FRAME_BITS-1:0];
         REG_FRAME_HEIGHT: cfg_shadow.frame_height = value[FRAME_BITS-1:0];
         REG_TILE_COLUMNS: cfg_shadow.tile_columns = value[COLS_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(int unsigned tw, int unsigned th, int unsigned fw,
                             int unsigned fh, int unsigned cols);
      wait_idle();
      write_reg(REG_TILE_WIDTH, CSR_DATA_BITS'(tw));
      write_reg(REG_TILE_HEIGHT, CSR_DATA_BITS'(th));
      write_reg(REG_FRAME_WIDTH, CSR_DATA_BITS'(fw));
      write_reg(REG_FRAME_HEIGHT, CSR_DATA_BITS'(fh));
      write_reg(REG_TILE_COLUMNS, CSR_DATA_BITS'(cols));
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int unsigned pick_tile();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 1;
         2: return 511;
         3: return 256;
         default: return $urandom_range(1, 256);
      endcase
   endfunction

   function automatic int unsigned pick_frame();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 1;
         2: return 16383;
         3: return 8192;
         default: return $urandom_range(1, 4096);
      endcase
   endfunction

   initial begin : stimulus
      int unsigned            phase, cols_pick, cols_n, span_cols, lo, hi;
      int unsigned            frame_rows, r, left_in_phase;
      logic [MAX_COLUMNS-1:0] prev_mask, used, mask;
      cfg_shadow.tile_width   = 64;
      cfg_shadow.tile_height  = 64;
      cfg_shadow.frame_width  = 1920;
      cfg_shadow.frame_height = 1080;
      cfg_shadow.tile_columns = 30;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: 64 pixel tiles, 1920 by 1080 frame, 30 columns.
      queue_row('0, 1'b1);
      queue_row(64'h7, 1'b0);
      queue_row(64'h7, 1'b0);
      queue_row(64'h20, 1'b0);
      queue_row('0, 1'b0);
      queue_row(64'h20, 1'b0);
      queue_row('1, 1'b1);
      queue_row(64'h8000_0000_0000_0000, 1'b1);

      // Largest tiles and frame, column count above the maximum.
      set_config(511, 511, 16383, 16383, 127);
      queue_row(64'h8000_0000_0000_0000, 1'b0);
      queue_row(64'h8000_0000_0000_0000, 1'b0);
      queue_row(64'h1, 1'b0);
      queue_row('1, 1'b1);

      // No columns in use: every row is clean.
      set_config(0, 0, 1, 1, 0);
      queue_row('1, 1'b0);
      queue_row('1, 1'b1);

      // Zero tile size gives empty boxes that still coalesce.
      set_config(0, 0, 100, 100, 64);
      queue_row(64'h1, 1'b0);
      queue_row(64'h1, 1'b0);
      queue_row(64'hF0, 1'b1);

      // One pixel frame: rows past the bottom saturate.
      set_config(1, 1, 1, 1, 1);
      queue_row(64'h1, 1'b0);
      queue_row(64'h1, 1'b0);
      queue_row(64'h1, 1'b0);
      queue_row(64'h1, 1'b1);

      set_config(256, 256, 8192, 8192, 64);
      queue_row(64'h8000_0000_0000_0001, 1'b0);
      queue_row(64'h8000_0000_0000_0001, 1'b1);

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 7))
            0: cols_pick = 0;
            1: cols_pick = 64;
            2: cols_pick = 127;
            3: cols_pick = 1;
            default: cols_pick = $urandom_range(1, 64);
         endcase
         set_config(pick_tile(), pick_tile(), pick_frame(), pick_frame(), cols_pick);
         cols_n = (cols_pick > MAX_COLUMNS) ? MAX_COLUMNS : cols_pick;
         used = (cols_n >= MAX_COLUMNS) ? '1 : ((64'd1 << cols_n) - 64'd1);
         span_cols = (cols_n == 0) ? MAX_COLUMNS : cols_n;
         prev_mask = '0;
         left_in_phase = ROWS_PER_PHASE;
         while (left_in_phase > 0) begin
            frame_rows = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                    : $urandom_range(1, 12);
            for (r = 1; r <= frame_rows && left_in_phase > 0; r++) begin
               // Repeated spans are common so that boxes grow over several rows.
               case ($urandom_range(0, 9))
                  0: mask = '0;
                  1, 2, 3: mask = prev_mask;
                  4, 5: begin
                     lo = $urandom_range(0, span_cols - 1);
                     hi = $urandom_range(lo, span_cols - 1);
                     mask = ({MAX_COLUMNS{1'b1}} >> (MAX_COLUMNS - 1 - (hi - lo))) << lo;
                  end
                  6: mask = 64'd1 << $urandom_range(0, span_cols - 1);
                  7: mask = {$urandom, $urandom};
                  8: mask = prev_mask | ({$urandom, $urandom} & ~used);
                  default: mask = '1;
               endcase
               prev_mask = mask;
               queue_row(mask, r == frame_rows || left_in_phase == 1);
               left_in_phase--;
            end
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && box_expect.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
